// ----- design/ct_pkg.sv -----
package ct_pkg;

  localparam int SET_DEPTH   = 1024;
  localparam int SET_CAP     = SET_DEPTH - 1;
  localparam int IDX_W       = $clog2(SET_DEPTH);
  localparam int POS_W       = IDX_W + 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_APPEND_SRC = 2'd0,
    CMD_APPEND_TGT = 2'd1,
    CMD_CLEAR      = 2'd2,
    CMD_XLATE      = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic             valid;
    cmd_e             cmd;
    logic [7:0]       data;
    logic             present;
    logic [IDX_W-1:0] fp_pos;
    logic             tgt_we;
    logic [IDX_W-1:0] tgt_idx;
    logic [IDX_W-1:0] src_cnt;
    logic [IDX_W-1:0] tgt_cnt;
  } lookup_t;

endpackage

// ----- design/ct_if.sv -----
interface ct_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink (input valid, input command, input data_byte, output ready);
endinterface

interface ct_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink (input valid, input out_byte, output ready);
endinterface

interface ct_cfg_if;
  logic valid;
  logic ready;
  logic negate_set;

  modport source (output valid, output negate_set, input ready);
  modport sink (input valid, input negate_set, output ready);
endinterface

// ----- design/ct_front.sv -----
module ct_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  ct_item_if.sink       item_i,
  input  logic          pop_i,
  output logic          head_valid_o,
  output ct_pkg::item_t head_o
);
  import ct_pkg::*;

  item_t             buf_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push;
  logic              pop;
  item_t             in_item;

  assign item_i.ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign push         = item_i.valid && item_i.ready;
  assign head_valid_o = (cnt_q != '0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = buf_q[rd_ptr_q];

  always_comb begin
    in_item.cmd  = cmd_e'(item_i.command);
    in_item.data = item_i.data_byte;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

// ----- design/ct_sets.sv -----
module ct_sets (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  ct_pkg::item_t   head_i,
  input  logic            adv_i,
  output ct_pkg::lookup_t look_o
);
  import ct_pkg::*;

  logic [255:0]     present_q, present_d;
  logic [IDX_W-1:0] src_cnt_q, src_cnt_d;
  logic [IDX_W-1:0] tgt_cnt_q, tgt_cnt_d;
  logic             take;
  logic             fp_we;
  logic             tgt_we;
  logic [IDX_W-1:0] fp_mem [256];
  logic [IDX_W-1:0] fp_rd_q;
  logic             valid_q;
  cmd_e             cmd_q;
  logic [7:0]       data_q;
  logic             hit_q;
  logic             tgt_we_q;
  logic [IDX_W-1:0] tgt_idx_q;
  logic [IDX_W-1:0] src_snap_q;
  logic [IDX_W-1:0] tgt_snap_q;

  assign take = adv_i && head_valid_i;

  always_comb begin
    present_d = present_q;
    src_cnt_d = src_cnt_q;
    tgt_cnt_d = tgt_cnt_q;
    fp_we     = 1'b0;
    tgt_we    = 1'b0;
    case (head_i.cmd)
      CMD_APPEND_SRC: begin
        if (src_cnt_q < IDX_W'(SET_CAP)) begin
          src_cnt_d = src_cnt_q + 1'b1;
          if (!present_q[head_i.data]) begin
            present_d[head_i.data] = 1'b1;
            fp_we = 1'b1;
          end
        end
      end
      CMD_APPEND_TGT: begin
        if (tgt_cnt_q < IDX_W'(SET_CAP)) begin
          tgt_cnt_d = tgt_cnt_q + 1'b1;
          tgt_we    = 1'b1;
        end
      end
      CMD_CLEAR: begin
        present_d = '0;
        src_cnt_d = '0;
        tgt_cnt_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      src_cnt_q <= '0;
      tgt_cnt_q <= '0;
      valid_q   <= 1'b0;
    end else if (adv_i) begin
      valid_q <= head_valid_i;
      if (head_valid_i) begin
        present_q <= present_d;
        src_cnt_q <= src_cnt_d;
        tgt_cnt_q <= tgt_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (fp_we) begin
        fp_mem[head_i.data] <= src_cnt_d;
      end
      fp_rd_q    <= fp_mem[head_i.data];
      cmd_q      <= head_i.cmd;
      data_q     <= head_i.data;
      hit_q      <= present_q[head_i.data];
      tgt_we_q   <= tgt_we;
      tgt_idx_q  <= tgt_cnt_q;
      src_snap_q <= src_cnt_q;
      tgt_snap_q <= tgt_cnt_q;
    end
  end

  always_comb begin
    look_o.valid   = valid_q;
    look_o.cmd     = cmd_q;
    look_o.data    = data_q;
    look_o.present = hit_q;
    look_o.fp_pos  = fp_rd_q;
    look_o.tgt_we  = tgt_we_q;
    look_o.tgt_idx = tgt_idx_q;
    look_o.src_cnt = src_snap_q;
    look_o.tgt_cnt = tgt_snap_q;
  end

endmodule

// ----- design/ct_map.sv -----
module ct_map (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ct_pkg::lookup_t look_i,
  input  logic            negate_i,
  ct_out_if.source        result_o,
  output logic            adv_o
);
  import ct_pkg::*;

  logic [7:0]       tgt_mem [SET_DEPTH];
  logic [7:0]       tgt_rd_q;
  logic             in_run_q, in_run_d;
  logic             out_valid_q;
  logic             sel_mem_q;
  logic [7:0]       byte_q;
  logic [POS_W-1:0] last;
  logic [POS_W-1:0] pos;
  logic             collapse;
  logic             emit;
  logic             sel_mem;
  logic [IDX_W-1:0] rd_idx;
  logic             we;

  assign adv_o           = !out_valid_q || result_o.ready;
  assign result_o.valid  = out_valid_q;
  assign result_o.out_byte = sel_mem_q ? tgt_rd_q : byte_q;
  assign we              = look_i.valid && look_i.tgt_we && (look_i.cmd == CMD_APPEND_TGT);

  always_comb begin
    last     = {1'b0, look_i.tgt_cnt};
    if (negate_i) begin
      pos = look_i.present ? '0 : last + 1'b1;
    end else begin
      pos = look_i.present ? {1'b0, look_i.fp_pos} : '0;
    end
    collapse = ({1'b0, look_i.src_cnt} > last) || negate_i;
    emit     = 1'b0;
    sel_mem  = 1'b0;
    rd_idx   = look_i.tgt_cnt - 1'b1;
    in_run_d = in_run_q;
    if (look_i.valid) begin
      case (look_i.cmd)
        CMD_CLEAR: begin
          in_run_d = 1'b0;
        end
        CMD_XLATE: begin
          if (collapse && (last != '0) && (pos >= last)) begin
            emit     = !in_run_q;
            sel_mem  = 1'b1;
            in_run_d = 1'b1;
          end else begin
            in_run_d = 1'b0;
            if (pos == '0) begin
              emit = 1'b1;
            end else if (last != '0) begin
              emit    = 1'b1;
              sel_mem = 1'b1;
              rd_idx  = IDX_W'(pos - 1'b1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      in_run_q    <= 1'b0;
    end else if (adv_o) begin
      out_valid_q <= emit;
      in_run_q    <= in_run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      if (we) begin
        tgt_mem[look_i.tgt_idx] <= look_i.data;
      end
      tgt_rd_q  <= tgt_mem[rd_idx];
      sel_mem_q <= sel_mem;
      byte_q    <= look_i.data;
    end
  end

endmodule

// ----- design/char_transliterator.sv -----
// Channel   Direction  Payload                      Transfer
// item_i    in         command[1:0], data_byte[7:0] valid && ready
// result_o  out        out_byte[7:0]                valid && ready
// cfg_i     in         negate_set                   valid && ready (ready always high)
//
// One item is taken per cycle while the queue has room; each translated byte
// passes the queue, the position store read and the target table read registers.
// Reset clears the queue, the presence bits, both counts and the run flag at once.
// A stalled output freezes the back pipeline, and the two-entry queue then fills
// before item_i.ready drops.
module char_transliterator (
  input  logic     clk_i,
  input  logic     rst_ni,
  ct_item_if.sink  item_i,
  ct_out_if.source result_o,
  ct_cfg_if.sink   cfg_i
);
  import ct_pkg::*;

  logic    negate_q;
  logic    head_valid;
  item_t   head;
  logic    adv;
  lookup_t look;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      negate_q <= 1'b0;
    end else if (cfg_i.valid) begin
      negate_q <= cfg_i.negate_set;
    end
  end

  ct_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_i),
    .pop_i        (adv),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  ct_sets u_sets (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .adv_i        (adv),
    .look_o       (look)
  );

  ct_map u_map (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .look_i   (look),
    .negate_i (negate_q),
    .result_o (result_o),
    .adv_o    (adv)
  );

endmodule
